FILE: rtl/assert_macros.svh
// assert_macros.svh: assertion macros for the clipper checker.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// an implication checked on every clock edge outside reset
`define CHK_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");
// an implication whose consequent is checked in the cycle after the antecedent
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");
`endif

FILE: rtl/scc_pkg.sv
// scc_pkg: fixed constants for the segment clipper.
// No dependencies.
package scc_pkg;
    localparam int CoordW = 24;
    localparam int ColorW = 24;
    localparam int OutColorW = 48;
    localparam int NumPlanes = 6;
endpackage

FILE: rtl/scc_stream_if.sv
// scc_stream_if: valid/ready channel carrying one item of W bits.
// No dependencies.
interface scc_stream_if #(
    parameter int W = 8
);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/scc_div.sv
// scc_div: pipelined signed divider, one quotient bit per stage, truncating.
// Depends on nothing; used by segment_clip_cube_color_core.
module scc_div #(
    parameter int NW = 48,
    parameter int DW = 26,
    parameter int QW = 24
) (
    input  logic                 clk,
    input  logic                 en,
    input  logic signed [NW-1:0] num,
    input  logic signed [DW-1:0] den,
    output logic [QW-1:0]        q_mag,
    output logic                 q_neg,
    output logic                 q_big
);
    // restoring division on magnitudes; quotient bits above QW flag overflow
    localparam int S = QW;
    logic [NW-1:0] rem_reg  [S+1];
    logic [DW-1:0] dv_reg   [S+1];
    logic [QW-1:0] qt_reg   [S+1];
    logic          neg_reg  [S+1];
    logic          big_reg  [S+1];
    logic [NW-1:0] nmag;
    logic [DW-1:0] dmag;
    logic [NW-1:0] hi_next;
    logic          big_next;

    always_comb
    begin
        nmag = num[NW-1] ? NW'(-num) : NW'(num);
        dmag = den[DW-1] ? DW'(-den) : DW'(den);
        // quotient >= 2^QW when num_mag >= dmag << QW
        hi_next = nmag >> QW;
        big_next = (hi_next >= NW'(dmag));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= nmag;
            dv_reg[0]  <= dmag;
            qt_reg[0]  <= '0;
            neg_reg[0] <= num[NW-1] ^ den[DW-1];
            big_reg[0] <= big_next;
        end
    end

    for (genvar k = 0; k < S; k++)
    begin : g_stage
        localparam int B = QW - 1 - k;
        logic [NW-1:0] part;
        logic          take;
        always_comb
        begin
            part = rem_reg[k] >> B;
            take = big_reg[k] ? 1'b0 : (part >= NW'(dv_reg[k]));
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1] <= take ? rem_reg[k] - (NW'(dv_reg[k]) << B) : rem_reg[k];
                qt_reg[k+1]  <= qt_reg[k] | (QW'(take) << B);
                dv_reg[k+1]  <= dv_reg[k];
                neg_reg[k+1] <= neg_reg[k];
                big_reg[k+1] <= big_reg[k];
            end
        end
    end

    assign q_mag   = qt_reg[S];
    assign q_neg   = neg_reg[S];
    assign q_big   = big_reg[S];
endmodule

FILE: rtl/scc_lerp.sv
// scc_lerp: two-stage base + floor(d * t / ONE) interpolator.
// Depends on nothing; used by segment_clip_cube_color_core.
module scc_lerp #(
    parameter int VW = 26,
    parameter int TW = 18,
    parameter int FB = 16,
    parameter int OW = 24
) (
    input  logic                 clk,
    input  logic                 en,
    input  logic signed [OW-1:0] base,
    input  logic signed [VW-1:0] d,
    input  logic signed [TW-1:0] t,
    output logic [OW-1:0]        res
);
    logic signed [VW+TW-1:0] prod_reg;
    logic signed [OW-1:0]    base_reg;
    logic signed [VW+TW-1:0] shifted;
    logic signed [VW+TW-1:0] sum_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= d * t;
            base_reg <= base;
        end
    end

    // arithmetic shift is floor division by ONE
    assign shifted = prod_reg >>> FB;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_reg <= shifted + (VW+TW)'(base_reg);
        end
    end

    assign res = sum_reg[OW-1:0];
endmodule

FILE: rtl/segment_clip_cube_color_core.sv
// Channel | dir | payload
// in      | in  | start/end xyz (6 x 24), color_start, color_end (2 x 24)
// out     | out | visible, clipped start/end xyz (6 x 24), two Q8.8 colors (2 x 48)
// One item per cycle unless stalled. An item taken passes through the input register,
// (FRAC_BITS+2) divider stages, 1 + 6 plane stages, 2 interpolation stages and
// 1 output register before its result is loaded.
// The whole pipeline advances together; it stalls only when the output register is
// full and not taken. rst_n clears the valid bits only.
// segment_clip_cube_color_core: top level; uses scc_pkg, scc_stream_if, scc_div, scc_lerp.
module segment_clip_cube_color_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    scc_stream_if.sink    in_ch,
    scc_stream_if.source  out_ch
);
    localparam int CW  = scc_pkg::CoordW;
    localparam int DW  = CW + 2;
    localparam int NW  = DW + FRAC_BITS + 1;
    localparam int QW  = FRAC_BITS + 2;
    localparam int TW  = FRAC_BITS + 3;
    localparam int PW  = 6 * CW + 2 * scc_pkg::ColorW;
    localparam int LAT = QW + 1;
    localparam int P   = scc_pkg::NumPlanes;

    logic en;
    logic out_valid_reg;
    assign en = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = en;

    logic [PW-1:0] pay;
    assign pay = in_ch.data;

    logic signed [CW-1:0] s [3];
    logic signed [DW-1:0] dd [3];
    logic signed [DW-1:0] pden [P];
    logic signed [NW-1:0] pnum [P];
    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            s[a]  = pay[a*CW +: CW];
            dd[a] = DW'($signed(pay[(a+3)*CW +: CW])) - DW'(s[a]);
            pden[2*a]   = dd[a];
            pden[2*a+1] = -dd[a];
            pnum[2*a]   = NW'(-(DW'(1) <<< FRAC_BITS) - DW'(s[a]));
            pnum[2*a+1] = NW'(DW'(s[a]) - (DW'(1) <<< FRAC_BITS));
        end
    end

    // dividers, one per plane
    logic [QW-1:0] qm [P];
    logic          qn [P];
    logic          qb [P];
    for (genvar p = 0; p < P; p++)
    begin : g_div
        scc_div #(.NW(NW), .DW(DW), .QW(QW)) u_div (
            .clk(clk), .en(en),
            .num(pnum[p] <<< FRAC_BITS), .den(pden[p]),
            .q_mag(qm[p]), .q_neg(qn[p]), .q_big(qb[p])
        );
    end

    // payload and den/num sign delay line alongside the dividers
    logic [PW-1:0] pd_reg [LAT];
    logic [P-1:0]  dz_reg [LAT], dp_reg [LAT], np_reg [LAT];
    logic [LAT-1:0] vd_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pd_reg[0] <= pay;
            for (int p = 0; p < P; p++)
            begin
                dz_reg[0][p] <= (pden[p] == '0);
                dp_reg[0][p] <= !pden[p][DW-1] && (pden[p] != '0);
                np_reg[0][p] <= !pnum[p][NW-1] && (pnum[p] != '0);
            end
            for (int k = 1; k < LAT; k++)
            begin
                pd_reg[k] <= pd_reg[k-1];
                dz_reg[k] <= dz_reg[k-1];
                dp_reg[k] <= dp_reg[k-1];
                np_reg[k] <= np_reg[k-1];
            end
        end
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vd_reg <= '0;
        else if (en)
            vd_reg <= {vd_reg[LAT-2:0], in_ch.valid};
    end

    // saturated t per plane
    localparam logic signed [TW-1:0] TMAX = TW'(2) <<< FRAC_BITS;
    logic signed [TW-1:0] tq [P];
    always_comb
    begin
        for (int p = 0; p < P; p++)
        begin
            if (qb[p] || ({1'b0, qm[p]} > TMAX))
                tq[p] = qn[p] ? -TMAX : TMAX;
            else
                tq[p] = qn[p] ? -TW'(qm[p]) : TW'(qm[p]);
        end
    end

    // plane stages: stage 0 latches all t; stage k+1 applies plane k
    logic signed [TW-1:0] tt_reg [P+1][P];
    logic signed [TW-1:0] te_reg [P+1], tl_reg [P+1];
    logic                 ok_reg [P+1];
    logic [PW-1:0]        pp_reg [P+1];
    logic [P-1:0]         pz_reg [P+1], ppos_reg [P+1], pn_reg [P+1];
    logic [P:0]           pv_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tt_reg[0] <= tq;
            te_reg[0] <= '0;
            tl_reg[0] <= TW'(1) <<< FRAC_BITS;
            ok_reg[0] <= 1'b1;
            pp_reg[0] <= pd_reg[LAT-1];
            pz_reg[0] <= dz_reg[LAT-1];
            ppos_reg[0] <= dp_reg[LAT-1];
            pn_reg[0] <= np_reg[LAT-1];
        end
    end
    for (genvar k = 0; k < P; k++)
    begin : g_plane
        logic signed [TW-1:0] t, te_n, tl_n;
        logic ok_n;
        always_comb
        begin
            t = tt_reg[k][k];
            te_n = te_reg[k];
            tl_n = tl_reg[k];
            ok_n = ok_reg[k];
            if (pz_reg[k][k])
            begin
                if (pn_reg[k][k])
                    ok_n = 1'b0;
            end
            else if (ppos_reg[k][k])
            begin
                if (t > tl_reg[k])
                    ok_n = 1'b0;
                else if (t > te_reg[k])
                    te_n = t;
            end
            else
            begin
                if (t < te_reg[k])
                    ok_n = 1'b0;
                else if (t < tl_reg[k])
                    tl_n = t;
            end
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                tt_reg[k+1] <= tt_reg[k];
                te_reg[k+1] <= ok_reg[k] ? te_n : te_reg[k];
                tl_reg[k+1] <= ok_reg[k] ? tl_n : tl_reg[k];
                ok_reg[k+1] <= ok_n;
                pp_reg[k+1] <= pp_reg[k];
                pz_reg[k+1] <= pz_reg[k];
                ppos_reg[k+1] <= ppos_reg[k];
                pn_reg[k+1] <= pn_reg[k];
            end
        end
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pv_reg <= '0;
        else if (en)
            pv_reg <= {pv_reg[P-1:0], vd_reg[LAT-1]};
    end

    // interpolation: 12 lerps (6 coords, 6 color channels)
    logic [PW-1:0] fp;
    logic signed [TW-1:0] fte, ftl;
    assign fp  = pp_reg[P];
    assign fte = te_reg[P];
    assign ftl = tl_reg[P];
    logic [CW-1:0] cres [6];
    logic [15:0]   kres [6];
    for (genvar a = 0; a < 3; a++)
    begin : g_coord
        logic signed [CW-1:0] sb;
        logic signed [DW-1:0] dv;
        assign sb = fp[a*CW +: CW];
        assign dv = DW'($signed(fp[(a+3)*CW +: CW])) - DW'(sb);
        scc_lerp #(.VW(DW), .TW(TW), .FB(FRAC_BITS), .OW(CW)) u_s (
            .clk(clk), .en(en), .base(sb), .d(dv), .t(fte), .res(cres[a]));
        scc_lerp #(.VW(DW), .TW(TW), .FB(FRAC_BITS), .OW(CW)) u_e (
            .clk(clk), .en(en), .base(sb), .d(dv), .t(ftl), .res(cres[a+3]));
    end
    for (genvar c = 0; c < 3; c++)
    begin : g_color
        localparam int SH = 8 * (2 - c);
        logic signed [15:0] cb;
        logic signed [17:0] cdv;
        assign cb  = {fp[6*CW + SH +: 8], 8'd0};
        assign cdv = {2'b00, fp[7*CW + SH +: 8], 8'd0} - {2'b00, cb};
        scc_lerp #(.VW(18), .TW(TW), .FB(FRAC_BITS), .OW(16)) u_s (
            .clk(clk), .en(en), .base(cb), .d(cdv), .t(fte), .res(kres[c]));
        scc_lerp #(.VW(18), .TW(TW), .FB(FRAC_BITS), .OW(16)) u_e (
            .clk(clk), .en(en), .base(cb), .d(cdv), .t(ftl), .res(kres[c+3]));
    end
    logic [1:0] lok_reg, lv_reg;
    always_ff @(posedge clk)
    begin
        if (en)
            lok_reg <= {lok_reg[0], ok_reg[P]};
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            lv_reg <= '0;
        else if (en)
            lv_reg <= {lv_reg[0], pv_reg[P]};
    end

    // output register; rejected items report all zeros
    logic [$bits(out_ch.data)-1:0] out_data_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= lv_reg[1];
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (lok_reg[1])
                out_data_reg <= {kres[3], kres[4], kres[5], kres[0], kres[1], kres[2],
                                 cres[5], cres[4], cres[3], cres[2], cres[1], cres[0],
                                 1'b1};
            else
                out_data_reg <= '0;
        end
    end
    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_data_reg;
endmodule

FILE: rtl/scc_checker.sv
// scc_checker: port-level checks on the clipper; bound into the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"
module scc_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         in_ready,
    input logic         out_valid,
    input logic         out_ready,
    input logic [240:0] out_data
);
    // a rejected item carries all zero fields
    `CHK_IMPLY(a_rej_zero, clk, rst_n, out_valid && !out_data[0], out_data == '0)
    // a stalled result holds
    `CHK_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))
    // input is taken whenever the output side is free
    `CHK_IMPLY(a_ready, clk, rst_n, !out_valid || out_ready, in_ready)
    // nothing is refused unless a result is pending
    `CHK_IMPLY(a_stall, clk, rst_n, !in_ready, out_valid && !out_ready)
endmodule

bind segment_clip_cube_color_core scc_checker u_chk (
    .clk(clk), .rst_n(rst_n),
    .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
);
